FILE: rtl/unique_ready_fifo_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unique ready FIFO
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_READY_FIFO_CORE_ASSERT_SVH
`define UNIQUE_READY_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define URF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urf assertion failed");

// Next-cycle implication, disabled while reset is active.
`define URF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urf assertion failed");

`endif

FILE: rtl/urf_pkg.sv
// ----------------------------------------------------------------------------
// urf_pkg
// Request codes and transfer payload types of the unique ready FIFO.
// ----------------------------------------------------------------------------
package urf_pkg;

    localparam int IDENT_W = 10;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t            req_type;
        logic [IDENT_W-1:0]   ident;
    } req_item_t;

    typedef struct packed {
        logic                 was_empty;
        logic                 pop_valid;
        logic [IDENT_W-1:0]   pop_ident;
        logic                 is_member;
        logic [COUNT_W-1:0]   entry_count;
    } rsp_item_t;

endpackage

FILE: rtl/unique_ready_fifo_core.sv
// ----------------------------------------------------------------------------
// unique_ready_fifo_core
// FIFO of identifiers that holds each identifier at most once.
// ----------------------------------------------------------------------------
// The transfer reads the membership bitmap and the order store into
// registers; EXEC, once the response register is free or draining, modifies
// and writes them back and loads the response register. The single-port
// bitmap, read then written for one request, keeps one request in flight. A
// clear request, and also reset, start a pass that writes zeros over the
// bitmap one entry per cycle, during which no request is taken. The response
// register lets a new request enter while the previous response still waits.
// ----------------------------------------------------------------------------
module unique_ready_fifo_core #(
    parameter int NUM_IDS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  urf_pkg::req_item_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output urf_pkg::rsp_item_t rsp
);

    localparam int PTR_W  = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int CNT_W  = $clog2(NUM_IDS + 1);
    localparam int WIDE_W = (PTR_W > urf_pkg::IDENT_W) ? PTR_W : urf_pkg::IDENT_W;
    localparam int OCCX_W = (CNT_W > urf_pkg::COUNT_W) ? CNT_W : urf_pkg::COUNT_W;

    // Controller states
    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // Storage: membership bitmap and circular order store
    logic                         member_mem [NUM_IDS];
    logic [urf_pkg::IDENT_W-1:0]  order_mem  [NUM_IDS];

    logic [1:0]                   state_reg, state_next;
    logic [PTR_W-1:0]             sweep_reg, sweep_next;
    logic [PTR_W-1:0]             head_reg, head_next;
    logic [PTR_W-1:0]             tail_reg, tail_next;
    logic [CNT_W-1:0]             occ_reg, occ_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    urf_pkg::rsp_item_t           rsp_reg, rsp_next;

    // Request captured at transfer and the registered memory reads
    urf_pkg::req_item_t           req_reg;
    logic                         member_rd_reg;
    logic [urf_pkg::IDENT_W-1:0]  order_rd_reg;

    logic                         accept;
    logic                         fire;
    logic [WIDE_W-1:0]            in_ident_wide;
    logic [WIDE_W-1:0]            req_ident_wide;
    logic [WIDE_W-1:0]            pop_ident_wide;
    logic                         req_in_range;
    logic                         pop_in_range;
    logic                         push_ok;
    logic [OCCX_W-1:0]            occ_wide;

    logic                         member_we;
    logic [PTR_W-1:0]             member_waddr;
    logic                         member_wbit;
    logic                         order_we;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    // Retire the request when the response register is free or being drained
    assign fire      = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);

    assign in_ident_wide  = WIDE_W'(req.ident);
    assign req_ident_wide = WIDE_W'(req_reg.ident);
    assign pop_ident_wide = WIDE_W'(order_rd_reg);
    assign req_in_range   = (32'(req_reg.ident) < 32'(NUM_IDS));
    assign pop_in_range   = (32'(order_rd_reg) < 32'(NUM_IDS));

    // A push lands only for a fresh, in-range identifier; uniqueness keeps
    // the count limit from ever being reached with a fresh one, but keep it.
    assign push_ok = (req_reg.req_type == urf_pkg::REQ_PUSH) && req_in_range
                     && !member_rd_reg && (occ_reg < CNT_W'(NUM_IDS));

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        begin
            if (p == PTR_W'(NUM_IDS - 1))
            begin
                n = '0;
            end
            else
            begin
                n = p + PTR_W'(1);
            end
            return n;
        end
    endfunction

    // Next state, pointer updates and response
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        member_we      = 1'b0;
        member_waddr   = sweep_reg;
        member_wbit    = 1'b0;
        order_we       = 1'b0;
        occ_wide       = '0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                // Zero one bitmap entry per cycle
                member_we = 1'b1;
                if (sweep_reg == PTR_W'(NUM_IDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + PTR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    rsp_next = '0;
                    unique case (req_reg.req_type)
                        urf_pkg::REQ_PUSH:
                        begin
                            rsp_next.was_empty = (occ_reg == '0);
                            if (push_ok)
                            begin
                                member_we    = 1'b1;
                                member_waddr = req_ident_wide[PTR_W-1:0];
                                member_wbit  = 1'b1;
                                order_we     = 1'b1;
                                tail_next    = ptr_advance(tail_reg);
                                occ_next     = occ_reg + CNT_W'(1);
                            end
                            state_next = ST_IDLE;
                        end
                        urf_pkg::REQ_POP:
                        begin
                            if (occ_reg != '0)
                            begin
                                rsp_next.pop_valid = 1'b1;
                                rsp_next.pop_ident = order_rd_reg;
                                head_next          = ptr_advance(head_reg);
                                occ_next           = occ_reg - CNT_W'(1);
                                member_we          = pop_in_range;
                                member_waddr       = pop_ident_wide[PTR_W-1:0];
                            end
                            state_next = ST_IDLE;
                        end
                        urf_pkg::REQ_QUERY:
                        begin
                            rsp_next.is_member = req_in_range && member_rd_reg;
                            state_next         = ST_IDLE;
                        end
                        urf_pkg::REQ_CLEAR:
                        begin
                            // Drop all entries, then wipe the bitmap
                            head_next  = '0;
                            tail_next  = '0;
                            occ_next   = '0;
                            sweep_next = '0;
                            state_next = ST_SWEEP;
                        end
                    endcase
                    occ_wide             = OCCX_W'(occ_next);
                    rsp_next.entry_count = occ_wide[urf_pkg::COUNT_W-1:0];
                    rsp_valid_next       = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: hold the response while stalled
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            req_reg <= req;
        end
    end

    // Bitmap memory: read at transfer, written when the request retires or by
    // the clearing pass
    always_ff @(posedge clk)
    begin
        if (member_we)
        begin
            member_mem[member_waddr] <= member_wbit;
        end
        if (accept)
        begin
            member_rd_reg <= member_mem[in_ident_wide[PTR_W-1:0]];
        end
    end

    // Order memory: the front entry is read at every transfer
    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[tail_reg] <= req_reg.ident;
        end
        if (accept)
        begin
            order_rd_reg <= order_mem[head_reg];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/urf_checker.sv
// ----------------------------------------------------------------------------
// urf_checker
// Port-level checks of the unique ready FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "unique_ready_fifo_core_assert.svh"

module urf_checker #(
    parameter int NUM_IDS = 1024
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input urf_pkg::req_item_t req,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input urf_pkg::rsp_item_t rsp
);

    logic req_xfer;
    logic [urf_pkg::IDENT_W-1:0] req_ident_seen;

    assign req_xfer       = req_valid && !req_stall;
    assign req_ident_seen = req.ident;

    // A stalled response holds
    `URF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
        rsp_valid && $stable(rsp))

    // One request in flight: a transfer always stalls the next cycle
    `URF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_xfer, req_stall)

    // Only one kind of answer per response
    `URF_ASSERT_NOW(a_one_answer, clk, rst_n, rsp_valid,
        $countones({rsp.was_empty, rsp.pop_valid, rsp.is_member}) <= 1)

    // A response without a popped entry carries no identifier
    `URF_ASSERT_NOW(a_pop_ident_zero, clk, rst_n, rsp_valid && !rsp.pop_valid,
        rsp.pop_ident == '0)

    // The count never passes the identifier space
    `URF_ASSERT_NOW(a_count_bound, clk, rst_n, rsp_valid,
        (32'(rsp.entry_count) <= 32'(NUM_IDS)) || (req_ident_seen != req.ident))

endmodule

bind unique_ready_fifo_core urf_checker #(
    .NUM_IDS (NUM_IDS)
) u_urf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: tb/unique_ready_fifo_core_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unique_ready_fifo_core_check
// Watches both channels of the unique ready FIFO. It keeps its own copy of
// the queue, predicts the response of every request transfer and compares
// each response transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module unique_ready_fifo_core_check #(
    parameter int NUM_IDS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  urf_pkg::req_item_t req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  urf_pkg::rsp_item_t rsp,
    output int unsigned        fail_count,
    output int unsigned        rsp_owed
);

    localparam int IDENT_W = urf_pkg::IDENT_W;
    localparam int COUNT_W = urf_pkg::COUNT_W;

    bit                 member_map [NUM_IDS];
    logic [IDENT_W-1:0] order_ring [NUM_IDS];
    logic [IDENT_W-1:0] head_ptr;
    logic [IDENT_W-1:0] tail_ptr;
    logic [COUNT_W-1:0] occupancy;

    urf_pkg::rsp_item_t due_rsp [$];

    function automatic logic [IDENT_W-1:0] step_ptr(input logic [IDENT_W-1:0] ptr);
        return (int'(ptr) == NUM_IDS - 1) ? '0 : ptr + IDENT_W'(1);
    endfunction

    function automatic void empty_queue();
        foreach (member_map[i])
            member_map[i] = 1'b0;
        head_ptr  = '0;
        tail_ptr  = '0;
        occupancy = '0;
    endfunction

    // Apply one request to the local queue and return its response.
    function automatic urf_pkg::rsp_item_t serve_request(input urf_pkg::req_item_t item);
        urf_pkg::rsp_item_t res;
        logic [IDENT_W-1:0] gone;
        res = '0;
        case (item.req_type)
            urf_pkg::REQ_PUSH:
            begin
                res.was_empty = (occupancy == '0);
                if (int'(item.ident) < NUM_IDS && !member_map[item.ident]
                        && occupancy < COUNT_W'(NUM_IDS))
                begin
                    member_map[item.ident] = 1'b1;
                    order_ring[tail_ptr]   = item.ident;
                    tail_ptr               = step_ptr(tail_ptr);
                    occupancy              = occupancy + COUNT_W'(1);
                end
            end
            urf_pkg::REQ_POP:
            begin
                if (occupancy != '0)
                begin
                    gone      = order_ring[head_ptr];
                    head_ptr  = step_ptr(head_ptr);
                    occupancy = occupancy - COUNT_W'(1);
                    if (int'(gone) < NUM_IDS)
                        member_map[gone] = 1'b0;
                    res.pop_valid = 1'b1;
                    res.pop_ident = gone;
                end
            end
            urf_pkg::REQ_QUERY:
            begin
                if (int'(item.ident) < NUM_IDS)
                    res.is_member = member_map[item.ident];
            end
            default:
                empty_queue();
        endcase
        res.entry_count = occupancy;
        return res;
    endfunction

    task automatic match_field(input string label, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        urf_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            empty_queue();
            due_rsp.delete();
        end
        else
        begin
            if (req_valid && !req_stall)
                due_rsp.push_back(serve_request(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp.size() == 0)
                begin
                    $display("%0t: response transfer with none expected, got %p", $time, rsp);
                    fail_count++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    match_field("was_empty", COUNT_W'(want.was_empty),
                                COUNT_W'(rsp.was_empty));
                    match_field("pop_valid", COUNT_W'(want.pop_valid),
                                COUNT_W'(rsp.pop_valid));
                    match_field("pop_ident", COUNT_W'(want.pop_ident),
                                COUNT_W'(rsp.pop_ident));
                    match_field("is_member", COUNT_W'(want.is_member),
                                COUNT_W'(rsp.is_member));
                    match_field("entry_count", want.entry_count, rsp.entry_count);
                end
            end
        end
        rsp_owed = due_rsp.size();
    end

endmodule

FILE: tb/unique_ready_fifo_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unique_ready_fifo_core_test
// Drives requests into the unique ready FIFO: a short directed opening, a
// mostly narrow-range mixed phase, a fill of the whole identifier space,
// pushes while full, a partial drain and a short mixed tail. Both channels
// idle at random; a separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module unique_ready_fifo_core_test;

    localparam int NUM_IDS = 1024;
    localparam int IDENT_W = urf_pkg::IDENT_W;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    urf_pkg::req_item_t req;
    logic               rsp_valid;
    logic               rsp_stall;
    urf_pkg::rsp_item_t rsp;

    int unsigned fail_count;
    int unsigned rsp_owed;

    // When set, neither side idles; re-picked every 64 transfers.
    bit quiet;
    int unsigned sent;

    always #5 clk = ~clk;

    unique_ready_fifo_core #(.NUM_IDS(NUM_IDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    unique_ready_fifo_core_check #(.NUM_IDS(NUM_IDS)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .rsp_owed   (rsp_owed)
    );

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mixed request mix: clears are rare since each one costs a full
    // bitmap wipe inside the block.
    function automatic urf_pkg::req_type_t random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return urf_pkg::REQ_PUSH;
        if (r < 73)
            return urf_pkg::REQ_POP;
        if (r < 97)
            return urf_pkg::REQ_QUERY;
        return urf_pkg::REQ_CLEAR;
    endfunction

    // Present one request and hold it until the transfer happens.
    // Called right after a rising edge; returns at the edge of the transfer,
    // leaving valid high so back-to-back transfers need no extra assignment.
    task automatic send(input urf_pkg::req_type_t kind, input logic [IDENT_W-1:0] id);
        urf_pkg::req_item_t item;
        int                 gap;
        item.req_type = kind;
        item.ident    = id;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
        if (sent % 64 == 0)
            quiet = ($urandom_range(0, 3) == 0);
    endtask

    // Receiver side: stall in runs of random length between runs of
    // open cycles. Each branch assigns the stall at most once per edge.
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        forever
        begin
            n = pick_gap();
            if (n != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int                 order [NUM_IDS];
        int                 pick;
        int                 hold;
        logic [IDENT_W-1:0] id;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        quiet     = 1'b0;
        sent      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: empty pop and query, both ident extremes,
        // duplicate push, alternating bit patterns, clear then reuse.
        send(urf_pkg::REQ_POP,   10'd0);
        send(urf_pkg::REQ_QUERY, 10'd0);
        send(urf_pkg::REQ_PUSH,  10'd0);
        send(urf_pkg::REQ_PUSH,  10'd1023);
        send(urf_pkg::REQ_PUSH,  10'd0);
        send(urf_pkg::REQ_QUERY, 10'd0);
        send(urf_pkg::REQ_QUERY, 10'd1023);
        send(urf_pkg::REQ_QUERY, 10'd512);
        send(urf_pkg::REQ_POP,   10'd0);
        send(urf_pkg::REQ_POP,   10'd1023);
        send(urf_pkg::REQ_POP,   10'd0);
        send(urf_pkg::REQ_PUSH,  10'd1023);
        send(urf_pkg::REQ_PUSH,  10'h155);
        send(urf_pkg::REQ_PUSH,  10'h2aa);
        send(urf_pkg::REQ_QUERY, 10'h2aa);
        send(urf_pkg::REQ_CLEAR, 10'h3ff);
        send(urf_pkg::REQ_QUERY, 10'h155);
        send(urf_pkg::REQ_POP,   10'd0);
        send(urf_pkg::REQ_PUSH,  10'd5);
        send(urf_pkg::REQ_POP,   10'd0);

        // Mixed phase: a narrow identifier range most of the time so that
        // duplicates and positive queries are common.
        for (int n = 0; n < 330; n++)
        begin
            if ($urandom_range(0, 3) != 0)
                id = IDENT_W'($urandom_range(0, 31));
            else
                id = IDENT_W'($urandom_range(0, NUM_IDS - 1));
            send(random_kind(), id);
        end

        // Fill: push every identifier once in shuffled order, with queries
        // sprinkled in. The queue ends full and the tail pointer wraps.
        foreach (order[i])
            order[i] = i;
        for (int i = NUM_IDS - 1; i > 0; i--)
        begin
            pick        = $urandom_range(0, i);
            hold        = order[i];
            order[i]    = order[pick];
            order[pick] = hold;
        end
        foreach (order[i])
        begin
            if ($urandom_range(0, 9) == 0)
                send(urf_pkg::REQ_QUERY, IDENT_W'($urandom_range(0, NUM_IDS - 1)));
            send(urf_pkg::REQ_PUSH, IDENT_W'(order[i]));
        end

        // Push while full: every one is a duplicate.
        for (int n = 0; n < 20; n++)
            send(urf_pkg::REQ_PUSH, IDENT_W'($urandom_range(0, NUM_IDS - 1)));

        // Drain part of the queue in fill order, checking membership on the way.
        for (int n = 0; n < 300; n++)
        begin
            if ($urandom_range(0, 6) == 0)
                send(urf_pkg::REQ_QUERY, IDENT_W'($urandom_range(0, NUM_IDS - 1)));
            send(urf_pkg::REQ_POP, IDENT_W'($urandom_range(0, NUM_IDS - 1)));
        end

        // Short mixed tail over the full identifier range.
        for (int n = 0; n < 30; n++)
            send(random_kind(), IDENT_W'($urandom_range(0, NUM_IDS - 1)));

        // Drop valid, let every owed response arrive, then allow a margin
        // for any stray transfer.
        req_valid <= 1'b0;
        @(posedge clk);
        while (rsp_owed != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0 && rsp_owed == 0)
            $display("unique_ready_fifo_core verification clean");
        else
            $display("unique_ready_fifo_core verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, bitmap wipes included.
    initial
    begin
        #30_000_000;
        $display("unique_ready_fifo_core verification failed");
        $finish;
    end

endmodule
